/* rtl/point_vortex_induced_velocity_defines.svh */
// ----------------------------------------------------------------------------
// Point vortex velocity unit: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POINT_VORTEX_INDUCED_VELOCITY_DEFINES_SVH
`define POINT_VORTEX_INDUCED_VELOCITY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PVIV_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PVIV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pviv_pkg.sv */
// ----------------------------------------------------------------------------
// Point vortex velocity unit: package
// Widths, constants, codes and the command and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pviv_pkg;

  localparam int DATA_W           = 32;
  localparam int SLOT_W           = 8;
  localparam int CFG_ACT_W        = 9;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_VORTICES_DEF = 256;

  // Magnitude of a coordinate difference fits 32 bits; r^2 needs 65.
  localparam int MAG_W  = 32;
  localparam int R2_W   = 65;
  localparam int PROD_W = 64;
  localparam int P_W    = 63;
  localparam int K_W    = 30;
  localparam int N_W    = 93;
  // Dividend after dropping the 2^16 scale of the denominator.
  localparam int DVD_W  = N_W - 16;
  localparam int Q_W    = 33;
  localparam int DCNT_W = $clog2(DVD_W);

  // round(2^32 / (2*pi))
  localparam logic [K_W-1:0] INV_TWO_PI = 30'd683565276;

  localparam logic [DATA_W-1:0] FREE_VX_RST = 32'h0001_0000;
  localparam logic [DATA_W-1:0] FREE_VY_RST = 32'h0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_VX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_VY = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_AXX, ST_AYY, ST_SAY, ST_SAX, ST_PXL, ST_PXH,
    ST_PYL, ST_PYH, ST_NFIN, ST_DLOAD, ST_DIV, ST_ACC, ST_SKIP, ST_FINISH
  } pviv_state_t;

  typedef enum logic [3:0] {
    MS_AXX, MS_AYY, MS_SAY, MS_SAX, MS_PXL, MS_PXH, MS_PYL, MS_PYH, MS_NFIN
  } mstep_t;

  typedef struct packed {
    logic   load;
    logic   start;
    logic   rd;
    logic   diff;
    logic   mul_en;
    mstep_t mstep;
    logic   div_load;
    logic   div_step;
    logic   acc;
    logic   skip;
    logic   publish;
  } pviv_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic r2_zero;
    logic div_last;
    logic entry_last;
    logic out_free;
  } pviv_status_t;

endpackage

`default_nettype wire

/* rtl/pviv_in_if.sv */
// ----------------------------------------------------------------------------
// Point vortex velocity unit: input channel
// Valid/ready channel carrying one load or query word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pviv_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [pviv_pkg::SLOT_W-1:0]        slot;
  logic signed [pviv_pkg::DATA_W-1:0] vortex_x;
  logic signed [pviv_pkg::DATA_W-1:0] vortex_y;
  logic signed [pviv_pkg::DATA_W-1:0] strength;
  logic signed [pviv_pkg::DATA_W-1:0] query_x;
  logic signed [pviv_pkg::DATA_W-1:0] query_y;

  modport source (output valid, cmd, slot, vortex_x, vortex_y, strength, query_x,
                  query_y, input ready);
  modport sink (input valid, cmd, slot, vortex_x, vortex_y, strength, query_x,
                query_y, output ready);
endinterface

`default_nettype wire

/* rtl/pviv_out_if.sv */
// ----------------------------------------------------------------------------
// Point vortex velocity unit: result channel
// Valid/ready channel carrying one velocity word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pviv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pviv_pkg::DATA_W-1:0] velocity_x;
  logic signed [pviv_pkg::DATA_W-1:0] velocity_y;
  logic                               on_vortex;
  logic                               saturated;

  modport source (output valid, velocity_x, velocity_y, on_vortex, saturated,
                  input ready);
  modport sink (input valid, velocity_x, velocity_y, on_vortex, saturated,
                output ready);
endinterface

`default_nettype wire

/* rtl/pviv_ram.sv */
// ----------------------------------------------------------------------------
// Point vortex velocity unit: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pviv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/pviv_ctrl.sv */
// ----------------------------------------------------------------------------
// Point vortex velocity unit: controller
// Sequences table reads, the multiply steps, the divider and accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pviv_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_query,
  output logic                   ready,
  input  pviv_pkg::pviv_status_t status,
  output pviv_pkg::pviv_cmd_t    cmd
);
  import pviv_pkg::*;

  pviv_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_query) begin
          state_next = status.n_zero ? ST_FINISH : ST_READ;
        end
      end
      ST_READ:  state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_AXX;
      ST_AXX:   state_next = ST_AYY;
      ST_AYY:   state_next = ST_SAY;
      ST_SAY:   state_next = ST_SAX;
      ST_SAX:   state_next = status.r2_zero ? ST_SKIP : ST_PXL;
      ST_PXL:   state_next = ST_PXH;
      ST_PXH:   state_next = ST_PYL;
      ST_PYL:   state_next = ST_PYH;
      ST_PYH:   state_next = ST_NFIN;
      ST_NFIN:  state_next = ST_DLOAD;
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC, ST_SKIP: state_next = status.entry_last ? ST_FINISH : ST_READ;
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd   = '0;
    ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ready     = 1'b1;
        cmd.load  = in_valid && !in_query;
        cmd.start = in_valid && in_query;
      end
      ST_READ:  cmd.rd = 1'b1;
      ST_DIFF:  cmd.diff = 1'b1;
      ST_AXX:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_AXX;  end
      ST_AYY:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_AYY;  end
      ST_SAY:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_SAY;  end
      ST_SAX:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_SAX;  end
      ST_PXL:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_PXL;  end
      ST_PXH:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_PXH;  end
      ST_PYL:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_PYL;  end
      ST_PYH:   begin cmd.mul_en = 1'b1; cmd.mstep = MS_PYH;  end
      ST_NFIN:  begin cmd.mul_en = 1'b1; cmd.mstep = MS_NFIN; end
      ST_DLOAD: cmd.div_load = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_ACC:   cmd.acc = 1'b1;
      ST_SKIP:  cmd.skip = 1'b1;
      ST_FINISH: cmd.publish = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pviv_datapath.sv */
// ----------------------------------------------------------------------------
// Point vortex velocity unit: datapath
// Vortex table, shared multiplier, two-lane divider, saturating sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pviv_datapath #(
  parameter int MAX_VORTICES = pviv_pkg::MAX_VORTICES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pviv_pkg::pviv_cmd_t                 cmd,
  output pviv_pkg::pviv_status_t              status,
  input  logic [pviv_pkg::CFG_ACT_W-1:0]      active_vortices,
  input  logic signed [pviv_pkg::DATA_W-1:0]  free_vx,
  input  logic signed [pviv_pkg::DATA_W-1:0]  free_vy,
  input  logic [pviv_pkg::SLOT_W-1:0]         slot,
  input  logic signed [pviv_pkg::DATA_W-1:0]  vortex_x,
  input  logic signed [pviv_pkg::DATA_W-1:0]  vortex_y,
  input  logic signed [pviv_pkg::DATA_W-1:0]  strength,
  input  logic signed [pviv_pkg::DATA_W-1:0]  query_x,
  input  logic signed [pviv_pkg::DATA_W-1:0]  query_y,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [pviv_pkg::DATA_W-1:0]  velocity_x,
  output logic signed [pviv_pkg::DATA_W-1:0]  velocity_y,
  output logic                                on_vortex,
  output logic                                saturated
);
  import pviv_pkg::*;

  localparam int AW = (MAX_VORTICES > 1) ? $clog2(MAX_VORTICES) : 1;
  localparam int CW = $clog2(MAX_VORTICES + 1);

  // Table
  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] idx;
  logic [CW-1:0] n_eff;
  logic [DATA_W-1:0] pos_x, pos_y, str;

  assign we    = cmd.load && (32'(slot) < 32'(MAX_VORTICES));
  assign waddr = AW'(slot);
  assign n_eff = (32'(active_vortices) > 32'(MAX_VORTICES)) ? CW'(MAX_VORTICES)
                                                            : CW'(active_vortices);

  pviv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VORTICES)) u_ram_x (
    .clk(clk), .we(we), .waddr(waddr), .wdata(vortex_x),
    .re(cmd.rd), .raddr(idx[AW-1:0]), .rdata(pos_x)
  );
  pviv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VORTICES)) u_ram_y (
    .clk(clk), .we(we), .waddr(waddr), .wdata(vortex_y),
    .re(cmd.rd), .raddr(idx[AW-1:0]), .rdata(pos_y)
  );
  pviv_ram #(.WIDTH(DATA_W), .DEPTH(MAX_VORTICES)) u_ram_s (
    .clk(clk), .we(we), .waddr(waddr), .wdata(strength),
    .re(cmd.rd), .raddr(idx[AW-1:0]), .rdata(str)
  );

  // Per-entry registers
  logic signed [DATA_W-1:0] qx, qy;
  logic [MAG_W-1:0]  ax, ay, ms;
  logic              s_neg, dx_neg, dy_neg;
  logic [PROD_W-1:0] preg;
  logic [R2_W-1:0]   r2;
  logic [P_W-1:0]    px, py;
  logic [N_W-1:0]    nx, ny;

  logic signed [DATA_W:0] dx, dy;
  logic [MAG_W-1:0]       mul_a, mul_b;

  assign dx = {qx[DATA_W-1], qx} - {pos_x[DATA_W-1], pos_x};
  assign dy = {qy[DATA_W-1], qy} - {pos_y[DATA_W-1], pos_y};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mstep)
      MS_AXX:  begin mul_a = ax; mul_b = ax; end
      MS_AYY:  begin mul_a = ay; mul_b = ay; end
      MS_SAY:  begin mul_a = ms; mul_b = ay; end
      MS_SAX:  begin mul_a = ms; mul_b = ax; end
      MS_PXL:  begin mul_a = px[31:0]; mul_b = MAG_W'(INV_TWO_PI); end
      MS_PXH:  begin mul_a = MAG_W'(px[P_W-1:32]); mul_b = MAG_W'(INV_TWO_PI); end
      MS_PYL:  begin mul_a = py[31:0]; mul_b = MAG_W'(INV_TWO_PI); end
      MS_PYH:  begin mul_a = MAG_W'(py[P_W-1:32]); mul_b = MAG_W'(INV_TWO_PI); end
      MS_NFIN: begin mul_a = '0; mul_b = '0; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Divider lanes: lane 0 is the x term, lane 1 the y term.
  logic [DVD_W-1:0]  dvd [2];
  logic [R2_W-1:0]   rem [2];
  logic [Q_W-1:0]    quo [2];
  logic              ovf [2];
  logic [DCNT_W-1:0] dcnt;

  logic [R2_W:0]     trial   [2];
  logic              ge      [2];
  logic [R2_W-1:0]   rem_next[2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l]    = {rem[l], dvd[l][DVD_W-1]};
      ge[l]       = trial[l] >= {1'b0, r2};
      rem_next[l] = ge[l] ? R2_W'(trial[l] - {1'b0, r2}) : trial[l][R2_W-1:0];
    end
  end

  // Term clipping and saturating accumulation.
  logic signed [DATA_W-1:0] acc      [2];
  logic signed [DATA_W-1:0] acc_next [2];
  logic                     lane_clip[2];
  logic                     neg      [2];
  logic [Q_W-1:0]           limit    [2];
  logic [DATA_W-1:0]        mag      [2];
  logic signed [DATA_W+1:0] term     [2];
  logic signed [DATA_W+1:0] sum      [2];
  logic                     over     [2];

  assign neg[0] = s_neg ^ ~dy_neg;
  assign neg[1] = s_neg ^ dx_neg;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      limit[l] = neg[l] ? {1'b0, 32'h8000_0000} : {1'b0, 32'h7FFF_FFFF};
      over[l]  = ovf[l] || (quo[l] > limit[l]);
      mag[l]   = over[l] ? limit[l][DATA_W-1:0] : quo[l][DATA_W-1:0];
      term[l]  = neg[l] ? -$signed({2'b00, mag[l]}) : $signed({2'b00, mag[l]});
      sum[l]   = $signed({{2{acc[l][DATA_W-1]}}, acc[l]}) + term[l];
      lane_clip[l] = over[l];
      if (sum[l] > $signed(34'sh0_7FFF_FFFF)) begin
        acc_next[l]  = 32'sh7FFF_FFFF;
        lane_clip[l] = 1'b1;
      end else if (sum[l] < -$signed(34'sh0_8000_0000)) begin
        acc_next[l]  = -32'sh8000_0000;
        lane_clip[l] = 1'b1;
      end else begin
        acc_next[l] = sum[l][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qx     <= query_x;
      qy     <= query_y;
      acc[0] <= free_vx;
      acc[1] <= free_vy;
    end
    if (cmd.diff) begin
      ax     <= dx[DATA_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
      ay     <= dy[DATA_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
      ms     <= str[DATA_W-1] ? (~str + 32'd1) : str;
      s_neg  <= str[DATA_W-1];
      dx_neg <= dx[DATA_W];
      dy_neg <= dy[DATA_W];
    end
    // Each step after MS_AXX consumes the product registered by the step before it.
    if (cmd.mul_en) begin
      preg <= {32'b0, mul_a} * {32'b0, mul_b};
      unique case (cmd.mstep)
        MS_AXX:  ;
        MS_AYY:  r2 <= {1'b0, preg};
        MS_SAY:  r2 <= r2 + {1'b0, preg};
        MS_SAX:  px <= preg[P_W-1:0];
        MS_PXL:  py <= preg[P_W-1:0];
        MS_PXH:  nx <= {29'b0, preg};
        MS_PYL:  nx <= nx + {preg[60:0], 32'b0};
        MS_PYH:  ny <= {29'b0, preg};
        MS_NFIN: ny <= ny + {preg[60:0], 32'b0};
        default: ;
      endcase
    end
    if (cmd.div_load) begin
      dvd[0] <= nx[N_W-1:16];
      dvd[1] <= ny[N_W-1:16];
      for (int l = 0; l < 2; l++) begin
        rem[l] <= '0;
        quo[l] <= '0;
        ovf[l] <= 1'b0;
      end
      dcnt <= DCNT_W'(DVD_W - 1);
    end
    if (cmd.div_step) begin
      for (int l = 0; l < 2; l++) begin
        dvd[l] <= {dvd[l][DVD_W-2:0], 1'b0};
        rem[l] <= rem_next[l];
        quo[l] <= {quo[l][Q_W-2:0], ge[l]};
        ovf[l] <= ovf[l] | quo[l][Q_W-1];
      end
      dcnt <= dcnt - DCNT_W'(1);
    end
    if (cmd.acc) begin
      acc[0] <= acc_next[0];
      acc[1] <= acc_next[1];
    end
    if (cmd.publish) begin
      velocity_x <= acc[0];
      velocity_y <= acc[1];
    end
  end

  logic hit, clip;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      hit       <= 1'b0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
      on_vortex <= 1'b0;
      saturated <= 1'b0;
    end else begin
      if (cmd.start) begin
        idx  <= '0;
        hit  <= 1'b0;
        clip <= 1'b0;
      end else if (cmd.acc || cmd.skip) begin
        idx <= idx + CW'(1);
      end
      if (cmd.skip) begin
        hit <= 1'b1;
      end
      if (cmd.acc) begin
        clip <= clip | lane_clip[0] | lane_clip[1];
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
        on_vortex <= hit;
        saturated <= clip;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.n_zero     = (n_eff == '0);
  assign status.r2_zero    = (r2 == '0);
  assign status.div_last   = (dcnt == '0);
  assign status.entry_last = ((CW+1)'(idx) + (CW+1)'(1)) == (CW+1)'(n_eff);
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

/* rtl/point_vortex_induced_velocity.sv */
// A load word writes one vortex entry, if its slot lies within the table, and gives
// no result. A query word occupies the block while it works through each active vortex
// (a vortex that sits exactly on the query point skips the divider), and its result
// is registered once the output register is free. Per vortex the time is set by one
// 32x32 multiplier shared over nine steps and a radix-2 divider that runs 77 steps for
// the x and y terms side by side. The result sits in an output register, and the
// next word is taken once a query has been handed to it. Free velocity takes effect
// at the next query, active count at once; the table has no reset and needs no clear.
// ----------------------------------------------------------------------------
// Point vortex velocity unit: top level
// Configuration registers, controller, datapath and channel hookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "point_vortex_induced_velocity_defines.svh"

module point_vortex_induced_velocity #(
  parameter int MAX_VORTICES = pviv_pkg::MAX_VORTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pviv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pviv_pkg::DATA_W-1:0]     cfg_data,
  pviv_in_if.sink                         items,
  pviv_out_if.source                      results
);
  import pviv_pkg::*;

  logic [CFG_ACT_W-1:0]     active_vortices;
  logic signed [DATA_W-1:0] free_vx, free_vy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_vortices <= '0;
      free_vx         <= FREE_VX_RST;
      free_vy         <= FREE_VY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE:  active_vortices <= cfg_data[CFG_ACT_W-1:0];
        CFG_FREE_VX: free_vx <= cfg_data;
        CFG_FREE_VY: free_vy <= cfg_data;
        default: ;
      endcase
    end
  end

  pviv_cmd_t    cmd;
  pviv_status_t status;

  pviv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_query (items.cmd == CMD_QUERY),
    .ready    (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pviv_datapath #(.MAX_VORTICES(MAX_VORTICES)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .active_vortices (active_vortices),
    .free_vx         (free_vx),
    .free_vy         (free_vy),
    .slot            (items.slot),
    .vortex_x        (items.vortex_x),
    .vortex_y        (items.vortex_y),
    .strength        (items.strength),
    .query_x         (items.query_x),
    .query_y         (items.query_y),
    .out_ready       (results.ready),
    .out_valid       (results.valid),
    .velocity_x      (results.velocity_x),
    .velocity_y      (results.velocity_y),
    .on_vortex       (results.on_vortex),
    .saturated       (results.saturated)
  );

  `PVIV_ASSERT_SAME(a_publish_free, clk, rst, cmd.publish, status.out_free, "result overwritten")
  `PVIV_ASSERT_SAME(a_skip_hit, clk, rst, cmd.skip, status.r2_zero, "skip without hit")
  `PVIV_ASSERT_NEXT(a_query_busy, clk, rst, items.valid && items.ready && items.cmd == CMD_QUERY, !items.ready, "word taken during query")
  `PVIV_ASSERT_NEXT(a_publish_shown, clk, rst, cmd.publish, results.valid, "result not shown")

endmodule

`default_nettype wire
